/* rtl/rwt_pkg.sv */
`timescale 1ns / 1ps
// Package for the RTT window tracker: word types, deque entry, FSM states,
// register indexes and constants. No dependencies.
package rwt_pkg;

    localparam int WINDOW_DEPTH_DEF = 32;
    localparam logic [36:0] LONG_WINDOW_FLOOR = 37'd10000000;
    localparam logic [4:0] MIN_WINDOW_FACTOR = 5'd20;
    localparam logic [31:0] INITIAL_RTT_RST = 32'd333000;
    localparam logic [31:0] GRANULARITY_RST = 32'd1000;

    typedef enum logic {
        CFG_INITIAL_RTT = 1'b0,
        CFG_GRANULARITY = 1'b1
    } t_cfg_index;

    typedef enum logic {
        FUNC_ADD   = 1'b0,
        FUNC_CLEAR = 1'b1
    } t_func;

    typedef struct packed {
        logic        func;
        logic [31:0] rtt_sample;
        logic [47:0] now_time;
    } t_in_word;

    typedef struct packed {
        logic [31:0] cur_rtt;
        logic [31:0] avg_rtt;
        logic [31:0] min_rtt;
        logic [31:0] floor_rtt;
    } t_out_word;

    typedef struct packed {
        logic [47:0] time_us;
        logic [31:0] value;
    } t_dq_entry;

    typedef struct packed {
        logic start;
        logic clear;
    } t_dq_ctrl;

    typedef struct packed {
        logic busy;
        logic nonempty;
    } t_dq_status;

    typedef enum logic [2:0] {
        DQ_IDLE,
        DQ_BACK_RD,
        DQ_BACK_CHK,
        DQ_PUSH,
        DQ_FRONT_RD,
        DQ_FRONT_CHK
    } t_dq_state;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WIN,
        ST_RUN,
        ST_WAIT,
        ST_OUT
    } t_top_state;

endpackage

/* rtl/rwt_deque.sv */
`timescale 1ns / 1ps
// Monotonic min-deque kept as a ring buffer in one synchronous RAM.
// Depends on rwt_pkg.
module rwt_deque import rwt_pkg::*; #(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dq_ctrl    i_ctrl,
    input  logic [31:0] i_sample,
    input  logic [47:0] i_now,
    input  logic [36:0] i_window,
    output t_dq_status  o_status,
    output logic [31:0] o_front
);

    localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam logic [CW:0] DEPTH_W = (CW + 1)'(WINDOW_DEPTH);

    t_dq_entry   mem [WINDOW_DEPTH];
    t_dq_entry   r_rd;
    t_dq_state   r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [31:0] r_front, n_front;
    logic [31:0] r_s;
    logic [47:0] r_now;
    logic [36:0] r_win;

    logic [AW-1:0] rd_addr, wr_addr, head_p;
    logic [CW-1:0] cnt_p;
    logic          wr_en, full, expired;

    function automatic logic [AW-1:0] wrap(input logic [AW-1:0] h, input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW + 1)'(h) + (CW + 1)'(off);
        if (sum >= DEPTH_W) sum = sum - DEPTH_W;
        return sum[AW-1:0];
    endfunction

    assign full    = (r_cnt == CW'(WINDOW_DEPTH));
    assign head_p  = full ? wrap(r_head, CW'(1)) : r_head;
    assign cnt_p   = full ? CW'(WINDOW_DEPTH - 1) : r_cnt;
    assign expired = ({1'b0, r_rd.time_us} + 49'(r_win)) < {1'b0, r_now};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            DQ_IDLE:      if (i_ctrl.start) n_state = DQ_BACK_RD;
            DQ_BACK_RD:   n_state = (r_cnt == '0) ? DQ_PUSH : DQ_BACK_CHK;
            DQ_BACK_CHK:  n_state = (r_rd.value > r_s) ? DQ_BACK_RD : DQ_PUSH;
            DQ_PUSH:      n_state = DQ_FRONT_RD;
            DQ_FRONT_RD:  n_state = (r_cnt > CW'(1)) ? DQ_FRONT_CHK : DQ_IDLE;
            DQ_FRONT_CHK: n_state = expired ? DQ_FRONT_RD : DQ_IDLE;
            default:      n_state = DQ_IDLE;
        endcase
    end

    always_comb begin
        n_head  = r_head;
        n_cnt   = r_cnt;
        n_front = r_front;
        rd_addr = r_head;
        wr_addr = wrap(head_p, cnt_p);
        wr_en   = 1'b0;
        unique case (r_state)
            DQ_IDLE: if (i_ctrl.clear) n_cnt = '0;
            DQ_BACK_RD: rd_addr = wrap(r_head, r_cnt - CW'(1));
            DQ_BACK_CHK: if (r_rd.value > r_s) n_cnt = r_cnt - CW'(1);
            DQ_PUSH: begin
                wr_en  = 1'b1;
                n_head = head_p;
                n_cnt  = cnt_p + CW'(1);
            end
            DQ_FRONT_RD: if (r_cnt <= CW'(1)) n_front = r_s;
            DQ_FRONT_CHK: begin
                if (expired) begin
                    n_head = wrap(r_head, CW'(1));
                    n_cnt  = r_cnt - CW'(1);
                end else begin
                    n_front = r_rd.value;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= '{time_us: r_now, value: r_s};
        r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DQ_IDLE;
            r_head  <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_cnt   <= n_cnt;
        end
        r_front <= n_front;
        if (r_state == DQ_IDLE && i_ctrl.start) begin
            r_s   <= i_sample;
            r_now <= i_now;
            r_win <= i_window;
        end
    end

    assign o_status.busy     = (r_state != DQ_IDLE);
    assign o_status.nonempty = (r_cnt != '0);
    assign o_front           = r_front;

endmodule

/* rtl/rtt_window_tracker_unit.sv */
`timescale 1ns / 1ps
// RTT window tracker top level: smoothing, window arithmetic and result word.
// Depends on rwt_pkg and rwt_deque.
//
// One input word either adds an RTT sample (func = add) or clears all
// history (func = clear); every word yields exactly one result word with
// latest, smoothed, windowed-minimum and unjittered RTT, reporting
// initial_rtt for any value that does not exist yet. The two minimum deques
// each live in a ring buffer RAM and update side by side; each walks its
// back (dropping larger values) and its front (dropping expired entries) one
// RAM read at a time. The input is stalled for a sample until both deques
// are idle again and the result is registered; a clear goes straight to
// the result. The back walk stops without a read once the deque is empty,
// and the front walk is skipped when a single entry remains after the push.
// The result sits in an output register, so the next word is taken while
// it waits. Configuration writes are always ready and also reach a word
// already in progress.
module rtt_window_tracker_unit import rwt_pkg::*; #(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_word    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_top_state  r_state, n_state;
    logic [31:0] r_init, r_gran;
    logic [31:0] r_smooth, r_last;
    logic        r_smooth_v, r_last_v;
    logic [31:0] r_s;
    logic [47:0] r_now;
    logic [36:0] r_long_win, r_short_win;
    logic        r_out_valid;
    t_out_word   r_out;

    t_dq_ctrl    long_ctrl, short_ctrl;
    t_dq_status  long_st, short_st;
    logic [31:0] long_front, short_front;

    logic        accept, is_clear, out_free;
    logic [31:0] s_fix, smooth_new, prev_min, smooth_fix;
    logic [35:0] acc;
    logic [36:0] long_raw, long_max, short_raw, short_min;

    assign accept   = i_in_valid && !o_in_stall;
    assign is_clear = (i_in_data.func == FUNC_CLEAR);
    assign out_free = !r_out_valid || !i_out_stall;

    // zero sample becomes the granularity
    assign s_fix = (i_in_data.rtt_sample != '0) ? i_in_data.rtt_sample : r_gran;
    // 15*srtt as 16*srtt - srtt
    assign acc   = 36'(s_fix) + ({r_smooth, 4'b0} - 36'(r_smooth));
    assign smooth_new = !r_smooth_v ? s_fix :
                        ((acc[35:4] != '0) ? acc[35:4] : r_gran);

    // window arithmetic, from the updated srtt and the previous minimum
    assign prev_min   = long_st.nonempty ? long_front : r_init;
    assign long_raw   = 37'((prev_min != '0) ? prev_min : r_gran) * 37'(MIN_WINDOW_FACTOR);
    assign long_max   = (long_raw < LONG_WINDOW_FLOOR) ? LONG_WINDOW_FLOOR : long_raw;
    assign smooth_fix = (r_smooth != '0) ? r_smooth : r_gran;
    assign short_raw  = 37'(smooth_fix >> 1);
    assign short_min  = (short_raw > long_max) ? long_max : short_raw;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (accept) n_state = is_clear ? ST_OUT : ST_WIN;
            ST_WIN:  n_state = ST_RUN;
            ST_RUN:  n_state = ST_WAIT;
            ST_WAIT: if (!long_st.busy && !short_st.busy) n_state = ST_OUT;
            ST_OUT:  if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall       = (r_state != ST_IDLE);
        long_ctrl.start  = (r_state == ST_RUN);
        short_ctrl.start = (r_state == ST_RUN);
        long_ctrl.clear  = accept && is_clear;
        short_ctrl.clear = accept && is_clear;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_init      <= INITIAL_RTT_RST;
            r_gran      <= GRANULARITY_RST;
            r_smooth_v  <= 1'b0;
            r_last_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_INITIAL_RTT: r_init <= i_cfg_data;
                    CFG_GRANULARITY: r_gran <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                r_smooth_v <= !is_clear;
                r_last_v   <= !is_clear;
            end
            if (r_state == ST_OUT && out_free) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
        if (accept && !is_clear) begin
            r_smooth <= smooth_new;
            r_last   <= s_fix;
            r_s      <= s_fix;
            r_now    <= i_in_data.now_time;
        end
        if (r_state == ST_WIN) begin
            r_long_win  <= (long_max != '0) ? long_max : 37'(r_gran);
            r_short_win <= (short_min != '0) ? short_min : 37'(r_gran);
        end
        if (r_state == ST_OUT && out_free) begin
            r_out.cur_rtt   <= r_last_v ? r_last : r_init;
            r_out.avg_rtt   <= r_smooth_v ? r_smooth : r_init;
            r_out.min_rtt   <= long_st.nonempty ? long_front : r_init;
            r_out.floor_rtt <= short_st.nonempty ? short_front : r_init;
        end
    end

    rwt_deque #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_long (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (long_ctrl),
        .i_sample (r_s),
        .i_now    (r_now),
        .i_window (r_long_win),
        .o_status (long_st),
        .o_front  (long_front)
    );

    rwt_deque #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_short (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (short_ctrl),
        .i_sample (r_s),
        .i_now    (r_now),
        .i_window (r_short_win),
        .o_status (short_st),
        .o_front  (short_front)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule
